// File: hdl/fifo_with_running_max_defines.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FIFO_WITH_RUNNING_MAX_DEFINES_SVH
`define FIFO_WITH_RUNNING_MAX_DEFINES_SVH

// Checks that the property holds at every clock edge outside reset.
`define FWRM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fifo_with_running_max check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FWRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fifo_with_running_max check failed");

`endif

// File: hdl/fwrm_pkg.sv
package fwrm_pkg;

    localparam int DEPTH  = 16;
    localparam int VAL_W  = 32;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                    op;
        logic signed [VAL_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        logic [1:0]              status;
        logic signed [VAL_W-1:0] queue_max;
        logic                    has_max;
        logic [COUNT_W-1:0]      occupancy;
    } rsp_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                    enq;
        logic                    deq;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    // Contents of one cell: the entry and the maximum over it and all younger entries.
    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] suffix_max;
    } cell_t;

endpackage

// File: hdl/fwrm_cell.sv
module fwrm_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  fwrm_pkg::cmd_t cmd,
    input  logic           prev_valid,
    input  fwrm_pkg::cell_t succ,
    output fwrm_pkg::cell_t state,
    output fwrm_pkg::cell_t state_next
);

    logic                        valid_reg;
    logic signed [fwrm_pkg::VAL_W-1:0] value_reg;
    logic signed [fwrm_pkg::VAL_W-1:0] max_reg;

    assign state.valid      = valid_reg;
    assign state.value      = value_reg;
    assign state.suffix_max = max_reg;

    always_comb
    begin
        state_next = state;
        if (cmd.deq)
        begin
            state_next = succ;
        end
        else if (cmd.enq)
        begin
            if (valid_reg)
            begin
                if (cmd.value > max_reg)
                begin
                    state_next.suffix_max = cmd.value;
                end
            end
            else if (prev_valid)
            begin
                state_next.valid      = 1'b1;
                state_next.value      = cmd.value;
                state_next.suffix_max = cmd.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= state_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= state_next.value;
        max_reg   <= state_next.suffix_max;
    end

endmodule

// File: hdl/fifo_with_running_max.sv
// Queue of signed 32-bit values that also reports the largest value it holds.
// The req channel carries one operation per transfer: an enqueue of value_in
// or a dequeue of the oldest entry. The rsp channel returns exactly one result
// per request, in order: the dequeued value, a status, the occupancy, and the
// maximum over the entries left after the operation.
// The entries live in a chain of cells with the oldest entry in the first cell.
// Each cell keeps the maximum over itself and every younger entry, so the
// queue maximum is always ready in the first cell; a dequeue shifts the whole
// chain by one cell and an enqueue fills the first empty cell.
// The result of a request is presented on rsp in the cycle after its transfer.
// Throughput is one request per cycle while rsp is not stalled, set by the
// single output register, which is freed in the same cycle it is taken.
// While rsp is stalled with a result waiting, req_stall is raised and the
// result is held unchanged. A dequeue from an empty queue and an enqueue to a
// full queue leave the queue unchanged and are reported in the status.
// Reset empties the queue and clears the output valid flag; no clearing pass.
module fifo_with_running_max (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  fwrm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output fwrm_pkg::rsp_t rsp
);

    localparam int DEPTH   = fwrm_pkg::DEPTH;
    localparam int COUNT_W = fwrm_pkg::COUNT_W;

    fwrm_pkg::cell_t cur [DEPTH+1];
    fwrm_pkg::cell_t nxt [DEPTH];
    fwrm_pkg::cmd_t  cmd;
    fwrm_pkg::rsp_t  rsp_reg;
    fwrm_pkg::rsp_t  rsp_next;
    logic            rsp_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic            accept;
    logic            empty;
    logic            full;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == COUNT_W'(DEPTH));

    assign cmd.enq   = accept && (req.op == fwrm_pkg::OP_ENQ) && !full;
    assign cmd.deq   = accept && (req.op == fwrm_pkg::OP_DEQ) && !empty;
    assign cmd.value = req.value_in;

    assign cur[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic prev_valid;
        if (i == 0)
        begin : g_first
            assign prev_valid = 1'b1;
        end
        else
        begin : g_rest
            assign prev_valid = cur[i-1].valid;
        end
        fwrm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_valid (prev_valid),
            .succ       (cur[i+1]),
            .state      (cur[i]),
            .state_next (nxt[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - COUNT_W'(1);
        end

        rsp_next.value_out = '0;
        rsp_next.status    = fwrm_pkg::ST_OK;
        if (req.op == fwrm_pkg::OP_DEQ)
        begin
            if (empty)
            begin
                rsp_next.status = fwrm_pkg::ST_EMPTY;
            end
            else
            begin
                rsp_next.value_out = cur[0].value;
            end
        end
        else if (full)
        begin
            rsp_next.status = fwrm_pkg::ST_FULL;
        end
        rsp_next.has_max   = nxt[0].valid;
        rsp_next.queue_max = nxt[0].valid ? nxt[0].suffix_max : '0;
        rsp_next.occupancy = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: hdl/fwrm_checker.sv
`include "fifo_with_running_max_defines.svh"

module fwrm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input fwrm_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input fwrm_pkg::rsp_t rsp
);

    logic enq_xfer;

    assign enq_xfer = req_valid && !req_stall && (req.op == fwrm_pkg::OP_ENQ);

    `FWRM_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    `FWRM_ASSERT_NEXT(a_enq_status, enq_xfer, rsp_valid && (rsp.status != fwrm_pkg::ST_EMPTY))
    `FWRM_ASSERT(a_has_max, !rsp_valid || (rsp.has_max == (rsp.occupancy != '0)))
    `FWRM_ASSERT(a_empty_max, !rsp_valid || rsp.has_max || (rsp.queue_max == '0))
    `FWRM_ASSERT(a_occ_range, !rsp_valid || (rsp.occupancy <= fwrm_pkg::COUNT_W'(fwrm_pkg::DEPTH)))

endmodule

bind fifo_with_running_max fwrm_checker u_fwrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
